// ===== rtl/feedback_delay_echo_unit_macros.svh =====
// Assertion macros used by the top level of the feedback delay echo unit.
`ifndef FEEDBACK_DELAY_ECHO_UNIT_MACROS_SVH
`define FEEDBACK_DELAY_ECHO_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FDEU_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FDEU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

// ===== rtl/fdeu_pkg.sv =====
// Shared types, constants and the saturation helper function of the feedback delay echo unit.
package fdeu_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int DELAY_W    = 15;
	localparam int GAIN_W     = 16;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int ROUND_SH   = 15;
	localparam int SAT_W      = 28;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_DELAY    = 2'd0;
	localparam logic [1:0] REG_FEEDBACK = 2'd1;
	localparam logic [1:0] REG_MIX      = 2'd2;

	localparam logic [DELAY_W-1:0] DELAY_RST    = 15'd18000;
	localparam logic [GAIN_W-1:0]  FEEDBACK_RST = 16'd13107;
	localparam logic [GAIN_W-1:0]  MIX_RST      = 16'd16384;
	localparam logic [GAIN_W-1:0]  Q15_ONE      = 16'h8000;

	localparam logic signed [SAT_W-1:0]    SAT_HI  = 28'sd8388607;
	localparam logic signed [SAT_W-1:0]    SAT_LO  = -28'sd8388608;
	localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

	// Effective gains after clamping to one.
	typedef struct packed {
		logic [GAIN_W-1:0] fb;
		logic [GAIN_W-1:0] mix;
	} gain_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_s24(input logic signed [SAT_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAT_HI) begin
			r = S24_MAX;
		end else if (v < SAT_LO) begin
			r = S24_MIN;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/fdeu_ring_ram.sv =====
// Simple dual-port ring memory with a registered read port.
module fdeu_ring_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// A read of the entry written in the same cycle returns the old content.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== rtl/fdeu_cfg.sv =====
// APB register file with the delay reduced modulo the ring depth and clamped gains.
module fdeu_cfg import fdeu_pkg::*; #(
	parameter int RING_DEPTH = 32768,
	localparam int IDX_W = $clog2(RING_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic [IDX_W-1:0]      dmod,
	output gain_t                 gains
);

	logic               wr;
	logic [DELAY_W-1:0] delay_q;
	logic [GAIN_W-1:0]  fb_q;
	logic [GAIN_W-1:0]  mix_q;

	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			fb_q    <= FEEDBACK_RST;
			mix_q   <= MIX_RST;
		end else if (wr) begin
			case (paddr[3:2])
				REG_DELAY:    delay_q <= pwdata[DELAY_W-1:0];
				REG_FEEDBACK: fb_q    <= pwdata[GAIN_W-1:0];
				REG_MIX:      mix_q   <= pwdata[GAIN_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DELAY:    prdata = APB_DATA_W'(delay_q);
			REG_FEEDBACK: prdata = APB_DATA_W'(fb_q);
			REG_MIX:      prdata = APB_DATA_W'(mix_q);
			default:      prdata = '0;
		endcase
	end

	assign gains.fb  = (fb_q > Q15_ONE) ? Q15_ONE : fb_q;
	assign gains.mix = (mix_q > Q15_ONE) ? Q15_ONE : mix_q;

	generate
		if (RING_DEPTH > (1 << DELAY_W) - 1) begin : g_no_wrap
			assign dmod = IDX_W'(delay_q);
		end else begin : g_wrap
			// Delay mod depth: quotient estimate by a reciprocal multiply taken at
			// the write, then one multiply back and at most one correction.
			localparam longint unsigned RECIP   = (64'd1 << 30) / RING_DEPTH;
			localparam int              RECIP_W = $clog2(RECIP + 1);
			localparam int              PROD_W  = DELAY_W + RECIP_W;
			localparam int              QUO_W   = PROD_W - 30;
			localparam longint unsigned PROD_RST = 64'(DELAY_RST) * RECIP;
			localparam logic [DELAY_W:0] DEPTH_V = (DELAY_W + 1)'(RING_DEPTH);
			localparam logic [IDX_W-1:0] DMOD_RST = IDX_W'(DELAY_RST % RING_DEPTH);

			logic [PROD_W-1:0]  prod_q;
			logic [QUO_W-1:0]   quo;
			logic [DELAY_W:0]   rem;
			logic [IDX_W-1:0]   dmod_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					prod_q <= PROD_W'(PROD_RST);
				end else if (wr && paddr[3:2] == REG_DELAY) begin
					prod_q <= PROD_W'(pwdata[DELAY_W-1:0]) * PROD_W'(RECIP);
				end
			end

			assign quo = prod_q[PROD_W-1:30];
			assign rem = (DELAY_W + 1)'(delay_q) - (DELAY_W + 1)'(32'(quo) * RING_DEPTH);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dmod_q <= DMOD_RST;
				end else begin
					dmod_q <= (rem >= DEPTH_V) ? IDX_W'(rem - DEPTH_V) : IDX_W'(rem);
				end
			end

			assign dmod = dmod_q;
		end
	endgenerate

endmodule

// ===== rtl/fdeu_dsp.sv =====
// Feedback and crossfade multipliers, then rounding and saturation.
module fdeu_dsp import fdeu_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [SAMPLE_W-1:0] x_s2,
	input  logic signed [SAMPLE_W-1:0] delayed_s2,
	input  gain_t                      gains,
	output logic signed [SAMPLE_W-1:0] wb_s3,
	output logic signed [SAMPLE_W-1:0] y_s3
);

	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [GAIN_W:0]       fb_g;
	logic signed [GAIN_W:0]       wet_g;
	logic signed [GAIN_W:0]       dry_g;
	logic signed [PROD_W-1:0]     fbp_s3;
	logic signed [PROD_W-1:0]     dry_s3;
	logic signed [PROD_W-1:0]     wet_s3;
	logic signed [SAMPLE_W-1:0]   x_s3;
	logic signed [PROD_W-1:0]     fb_sum;
	logic signed [SAT_W-1:0]      wb_sum;
	logic signed [SUM_W-1:0]      mix_sum;

	assign fb_g  = $signed({1'b0, gains.fb});
	assign wet_g = $signed({1'b0, gains.mix});
	assign dry_g = $signed({1'b0, Q15_ONE - gains.mix});

	always_ff @(posedge clk) begin
		if (en) begin
			fbp_s3 <= delayed_s2 * fb_g;
			wet_s3 <= delayed_s2 * wet_g;
			dry_s3 <= x_s2 * dry_g;
			x_s3   <= x_s2;
		end
	end

	// Round half up: add one half, then drop the fraction with an arithmetic shift.
	assign fb_sum  = fbp_s3 + $signed(PROD_W'(1 << (ROUND_SH - 1)));
	assign wb_sum  = SAT_W'(x_s3) + SAT_W'($signed(fb_sum[PROD_W-1:ROUND_SH]));
	assign mix_sum = SUM_W'(dry_s3) + SUM_W'(wet_s3) + $signed(SUM_W'(1 << (ROUND_SH - 1)));

	assign wb_s3 = sat_s24(wb_sum);
	assign y_s3  = sat_s24(SAT_W'($signed(mix_sum[SUM_W-1:ROUND_SH])));

endmodule

// ===== rtl/feedback_delay_echo_unit.sv =====
// Top level of the feedback delay echo unit: pipeline control, positions, ring, output.
//
//  Channel   Direction  Handshake                    Payload
//  s_*       in         s_tvalid / s_tready          s_tdata sample_in, s_tuser channel
//  m_*       out        m_tvalid / m_tready          m_tdata sample_out
//  APB       in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An accepted sample gives its result on m_tdata after stages one to three and the output
// register; one sample enters per cycle while the output does not stall, except that a sample
// reading the entry its same-channel predecessor is about to write waits while that one is in stage two.
// Reset clears positions and fill flags at once; the ring itself is not swept, unwritten
// entries read as zero through the per-channel fill state.
// A stalled m_tready holds the pipeline once the output register and stage three are full.
// A delay write takes effect through dmod; when the delay wraps, dmod passes prod_q and dmod_q first.
`include "feedback_delay_echo_unit_macros.svh"

module feedback_delay_echo_unit import fdeu_pkg::*; #(
	parameter int RING_DEPTH   = 32768,
	parameter int NUM_CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
	input  logic                  s_tuser,   // [0] channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_W  = $clog2(RING_DEPTH);
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int ADDR_W = CH_W + IDX_W;

	logic [IDX_W-1:0]  dmod;
	gain_t             gains;

	logic              s_fire;
	logic              s1_fire;
	logic              move;
	logic              hazard;

	logic              v_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [CH_W-1:0]   ch_s1;

	logic [IDX_W-1:0]  pos_q [NUM_CHANNELS];
	logic              full_q [NUM_CHANNELS];
	logic [IDX_W-1:0]  pos_cur;
	logic              full_cur;
	logic [IDX_W-1:0]  pos_nxt;
	logic              pos_wrap;
	logic [IDX_W:0]    back_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic              rd_ok;
	logic [ADDR_W-1:0] raddr_s1;
	logic [ADDR_W-1:0] waddr_s1;

	logic              v_s2;
	logic signed [SAMPLE_W-1:0] x_s2;
	logic [ADDR_W-1:0] raddr_s2;
	logic [ADDR_W-1:0] waddr_s2;
	logic              rd_ok_s2;
	logic [SAMPLE_W-1:0] rdata;
	logic              fwd_hit;
	logic signed [SAMPLE_W-1:0] delayed_s2;

	logic              v_s3;
	logic [ADDR_W-1:0] waddr_s3;
	logic signed [SAMPLE_W-1:0] wb_s3;
	logic signed [SAMPLE_W-1:0] y_s3;
	logic              we;

	logic              lastw_v_q;
	logic [ADDR_W-1:0] lastw_addr_q;
	logic [SAMPLE_W-1:0] lastw_data_q;

	logic              out_v_q;
	logic [SAMPLE_W-1:0] out_data_q;

	fdeu_cfg #(
		.RING_DEPTH(RING_DEPTH)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.dmod(dmod),
		.gains(gains)
	);

	assign pready = 1'b1;

	// Pipeline advance: blocked only when stage three holds a result the output
	// register cannot take.
	assign move     = !v_s3 || !out_v_q || m_tready;
	assign s1_fire  = v_s1 && move && !hazard;
	assign s_tready = !v_s1 || s1_fire;
	assign s_fire   = s_tvalid && s_tready;

	// Stage one: channel position lookup and ring address generation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			x_s1  <= $signed(s_tdata);
			ch_s1 <= (NUM_CHANNELS > 1) ? CH_W'(s_tuser) : '0;
		end
	end

	assign pos_cur  = pos_q[ch_s1];
	assign full_cur = full_q[ch_s1];
	assign pos_wrap = (pos_cur == IDX_W'(RING_DEPTH - 1));
	assign pos_nxt  = pos_wrap ? '0 : pos_cur + 1'b1;
	assign back_idx = {1'b0, pos_cur} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, dmod};
	assign rd_idx   = (pos_cur >= dmod) ? pos_cur - dmod : back_idx[IDX_W-1:0];
	// Entries are written in position order, so an entry below the position, or any
	// entry once the channel has wrapped, holds written data.
	assign rd_ok    = full_cur || (rd_idx < pos_cur);
	assign raddr_s1 = {ch_s1, rd_idx};
	assign waddr_s1 = {ch_s1, pos_cur};

	// The item in stage two writes its entry only from stage three; a read of that
	// entry now would miss it.
	assign hazard = v_s2 && (raddr_s1 == waddr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pos_q[i]  <= '0;
				full_q[i] <= 1'b0;
			end
		end else if (s1_fire) begin
			pos_q[ch_s1] <= pos_nxt;
			if (pos_wrap) begin
				full_q[ch_s1] <= 1'b1;
			end
		end
	end

	fdeu_ring_ram #(
		.ADDR_W(ADDR_W),
		.DATA_W(SAMPLE_W)
	) u_ring (
		.clk(clk),
		.we(we),
		.waddr(waddr_s3),
		.wdata(wb_s3),
		.re(s1_fire),
		.raddr(raddr_s1),
		.rdata(rdata)
	);

	// Stage two: delayed sample from the ring, the last write, or zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (move) begin
			v_s2 <= s1_fire;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			x_s2     <= x_s1;
			raddr_s2 <= raddr_s1;
			waddr_s2 <= waddr_s1;
			rd_ok_s2 <= rd_ok;
		end
		if (move) begin
			waddr_s3 <= waddr_s2;
		end
	end

	assign fwd_hit    = lastw_v_q && (lastw_addr_q == raddr_s2);
	assign delayed_s2 = !rd_ok_s2 ? '0 : (fwd_hit ? $signed(lastw_data_q) : $signed(rdata));

	fdeu_dsp u_dsp (
		.clk(clk),
		.en(move),
		.x_s2(x_s2),
		.delayed_s2(delayed_s2),
		.gains(gains),
		.wb_s3(wb_s3),
		.y_s3(y_s3)
	);

	// Stage three: write back and hand the result to the output register.
	assign we = v_s3 && move;

	// Copy of the write made at the edge the stage two item issued its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastw_v_q <= 1'b0;
		end else if (move) begin
			lastw_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			lastw_addr_q <= waddr_s3;
			lastw_data_q <= wb_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (we) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			out_data_q <= y_s3;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

	`FDEU_ASSERT_NOW(a_no_read_of_pending_write, clk, arst_n, v_s2 && s1_fire, raddr_s1 != waddr_s2, "ring read issued for an entry still in flight")
	`FDEU_ASSERT_NOW(a_forward_within_fill, clk, arst_n, v_s2 && fwd_hit, rd_ok_s2, "forwarded entry lies outside the fill state")
	`FDEU_ASSERT_NEXT(a_result_reaches_output, clk, arst_n, v_s3 && move, m_tvalid, "written item left no result")

endmodule
